>>> src/wrq_pkg.sv
// weighted running quantile: shared types and constants
// payload structs for the command and result words, multiplier operand select
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wrq_pkg;

  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned PCT_BITS     = 14;
  localparam int unsigned COUNT_BITS   = 9;
  localparam int unsigned DEF_CAPACITY = 256;

  localparam logic [PCT_BITS-1:0] PCT_RESET  = 14'd5000;
  localparam logic [PCT_BITS-1:0] FULL_SCALE = 14'd10000;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic signed [VALUE_BITS-1:0]  sample_value;
    logic        [WEIGHT_BITS-1:0] sample_weight;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] quantile_value;
    logic        [COUNT_BITS-1:0] entry_count;
    logic                         insert_dropped;
  } res_t;

  typedef enum logic [1:0] {
    MUL_GOAL = 2'b01,
    MUL_CUM  = 2'b10
  } mul_sel_e;

endpackage

`default_nettype wire

>>> src/wrq_mul_cmp.sv
// weighted running quantile: shared multiply and compare unit
// forms percentile * total once per insert, then cum * full scale per scan step
// depends on wrq_pkg
`timescale 1ns / 1ps
`default_nettype none

module wrq_mul_cmp #(
  parameter int unsigned SumW = 25
) (
  input  wrq_pkg::mul_sel_e                     sel_i,
  input  logic [wrq_pkg::PCT_BITS-1:0]          pct_i,
  input  logic [SumW-1:0]                       total_i,
  input  logic [SumW-1:0]                       cum_i,
  input  logic [SumW+wrq_pkg::PCT_BITS-1:0]     goal_i,
  output logic [SumW+wrq_pkg::PCT_BITS-1:0]     prod_o,
  output logic                                  ge_o
);
  import wrq_pkg::*;

  localparam int unsigned ProdW = SumW + PCT_BITS;

  logic [SumW-1:0]     op_a;
  logic [PCT_BITS-1:0] op_b;

  always_comb begin
    unique case (sel_i)
      MUL_GOAL: begin
        op_a = total_i;
        op_b = pct_i;
      end
      MUL_CUM: begin
        op_a = cum_i;
        op_b = FULL_SCALE;
      end
      default: begin
        op_a = cum_i;
        op_b = FULL_SCALE;
      end
    endcase
  end

  assign prod_o = ProdW'(op_a) * ProdW'(op_b);
  assign ge_o   = (prod_o >= goal_i);

endmodule

`default_nettype wire

>>> src/weighted_running_quantile.sv
// weighted running quantile: top level, sequencer and sorted pair memory
// depends on wrq_pkg and wrq_mul_cmp
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A command word (req_i) is taken at a clock edge with start high and busy low.
// Insert places the (value, weight) pair in a value-sorted list; clear empties it.
// Each command gives exactly one result word on res_o, shown for one cycle with
// res_valid_o high; the receiver cannot stall, so it must take it then.
// The percentile register is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle, as the block itself does not enforce it.
// A clear, or an insert into a full list, gives its result in the cycle after the
// command. An insert into a list with entries held walks the list from the top,
// reading each entry compared, then comparing it and moving it up one place; it
// then writes the pair, forms the goal product, and in the quantile scan reads,
// sums and compares each entry in turn. All of it uses the one pair memory and
// the one shared multiplier.
// busy falls in the cycle that the result is shown; the next command can follow.
// After reset the list is empty, the percentile is 50.00 percent and no result
// is pending; the pair memory needs no clearing as only held entries are read.

module weighted_running_quantile #(
  parameter int unsigned CAPACITY = wrq_pkg::DEF_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  wrq_pkg::req_t                   req_i,
  output logic                            res_valid_o,
  output wrq_pkg::res_t                   res_o,
  input  logic                            cfg_we_i,
  input  logic [wrq_pkg::PCT_BITS-1:0]    cfg_wdata_i
);
  import wrq_pkg::*;

  localparam int unsigned IdxW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned SumW   = WEIGHT_BITS + CntW;
  localparam int unsigned ProdW  = SumW + PCT_BITS;
  localparam int unsigned EntryW = VALUE_BITS + WEIGHT_BITS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SH_RD  = 8'b0000_0010,
    S_SH_CMP = 8'b0000_0100,
    S_PUT    = 8'b0000_1000,
    S_GOAL   = 8'b0001_0000,
    S_Q_RD   = 8'b0010_0000,
    S_Q_ADD  = 8'b0100_0000,
    S_Q_CMP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SumW-1:0]        total_q, total_d;
  logic [SumW-1:0]        cum_q, cum_d;
  logic [ProdW-1:0]       goal_q, goal_d;
  logic [IdxW-1:0]        ptr_q, ptr_d;
  logic [VALUE_BITS-1:0]  qval_q, qval_d;
  logic [VALUE_BITS-1:0]  v_q, v_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [PCT_BITS-1:0]    pct_q;
  logic                   res_valid_q, res_valid_d;
  res_t                   res_q, res_d;

  // pair memory, value in the upper bits
  logic [EntryW-1:0]      mem_q [CAPACITY];
  logic [EntryW-1:0]      rd_q;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [EntryW-1:0]      mem_wdata;

  logic [VALUE_BITS-1:0]  rd_val;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [CntW-1:0]        cnt_m1;
  logic                   full;
  logic                   last;
  logic [CntW+COUNT_BITS-1:0] cnt_ext;

  mul_sel_e               mul_sel;
  logic [ProdW-1:0]       mul_prod;
  logic                   mul_ge;

  assign rd_val  = rd_q[EntryW-1 -: VALUE_BITS];
  assign rd_w    = rd_q[WEIGHT_BITS-1:0];
  assign cnt_m1  = cnt_q - 1'b1;
  assign full    = (cnt_q == CntW'(CAPACITY));
  assign last    = (CntW'(ptr_q) == cnt_m1);
  assign cnt_ext = {{COUNT_BITS{1'b0}}, cnt_q};
  assign busy    = (state_q != S_IDLE);

  wrq_mul_cmp #(
    .SumW (SumW)
  ) u_mul_cmp (
    .sel_i   (mul_sel),
    .pct_i   (pct_q),
    .total_i (total_q),
    .cum_i   (cum_q),
    .goal_i  (goal_q),
    .prod_o  (mul_prod),
    .ge_o    (mul_ge)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    cum_d       = cum_q;
    goal_d      = goal_q;
    ptr_d       = ptr_q;
    qval_d      = qval_q;
    v_d         = v_q;
    w_d         = w_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q + 1'b1;
    mem_wdata   = rd_q;
    mul_sel     = MUL_CUM;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.opcode == OP_CLEAR) begin
            cnt_d                = '0;
            total_d              = '0;
            qval_d               = '0;
            res_valid_d          = 1'b1;
            res_d.quantile_value = '0;
            res_d.entry_count    = '0;
            res_d.insert_dropped = 1'b0;
          end else if (full) begin
            res_valid_d          = 1'b1;
            res_d.quantile_value = qval_q;
            res_d.entry_count    = cnt_ext[COUNT_BITS-1:0];
            res_d.insert_dropped = 1'b1;
          end else begin
            v_d = req_i.sample_value;
            w_d = req_i.sample_weight;
            if (cnt_q == '0) begin
              ptr_d   = '0;
              state_d = S_PUT;
            end else begin
              ptr_d   = cnt_m1[IdxW-1:0];
              state_d = S_SH_RD;
            end
          end
        end
      end
      S_SH_RD: begin
        state_d = S_SH_CMP;
      end
      S_SH_CMP: begin
        // walk down from the top, moving up every entry not less than the new value
        if ($signed(rd_val) < $signed(v_q)) begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_PUT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q + 1'b1;
          mem_wdata = rd_q;
          if (ptr_q == '0) begin
            state_d = S_PUT;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = S_SH_RD;
          end
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {v_q, w_q};
        cnt_d     = cnt_q + 1'b1;
        total_d   = total_q + SumW'(w_q);
        state_d   = S_GOAL;
      end
      S_GOAL: begin
        mul_sel = MUL_GOAL;
        goal_d  = mul_prod;
        ptr_d   = '0;
        cum_d   = '0;
        state_d = S_Q_RD;
      end
      S_Q_RD: begin
        state_d = S_Q_ADD;
      end
      S_Q_ADD: begin
        cum_d   = cum_q + SumW'(rd_w);
        qval_d  = rd_val;
        state_d = S_Q_CMP;
      end
      S_Q_CMP: begin
        mul_sel = MUL_CUM;
        // stop at the first position meeting the goal, or saturate at the last
        if (mul_ge || last) begin
          res_valid_d          = 1'b1;
          res_d.quantile_value = qval_q;
          res_d.entry_count    = cnt_ext[COUNT_BITS-1:0];
          res_d.insert_dropped = 1'b0;
          state_d              = S_IDLE;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_Q_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      qval_q      <= '0;
      pct_q       <= PCT_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      qval_q      <= qval_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        pct_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q  <= cum_d;
    goal_q <= goal_d;
    ptr_q  <= ptr_d;
    v_q    <= v_d;
    w_q    <= w_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[ptr_q];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a result only appears once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while still busy");

  // a clear command answers in the next cycle with an empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.opcode == OP_CLEAR) |=>
      (res_valid_o && res_o.entry_count == '0 && res_o.quantile_value == '0))
    else $error("clear did not answer with an empty list");

  // the fill count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // an empty list always reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cnt_q == '0) |-> (res_o.quantile_value == '0))
    else $error("empty list reported a nonzero quantile");

  // a dropped insert leaves the count at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.insert_dropped) |-> full)
    else $error("insert dropped while list not full");

endmodule

`default_nettype wire

>>> tb/sv/weighted_running_quantile_test.sv
// testbench for weighted_running_quantile: sends insert and clear words, keeps its
// own sorted pair list to predict every result word and checks each one as it comes
// depends on wrq_pkg and the weighted_running_quantile rtl
`timescale 1ns / 1ps

module weighted_running_quantile_test;
  import wrq_pkg::*;

  localparam int unsigned HALF_PERIOD  = 2;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned LIST_DEPTH   = DEF_CAPACITY;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_WORDS = 780;
  localparam logic [PCT_BITS-1:0] PCT_MAX = '1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  req_t                req_i       = '0;
  logic                res_valid_o;
  res_t                res_o;
  logic                cfg_we_i    = 1'b0;
  logic [PCT_BITS-1:0] cfg_wdata_i = '0;

  // predicted contents of the sorted pair list
  logic signed [VALUE_BITS-1:0] list_value  [LIST_DEPTH];
  logic        [WEIGHT_BITS-1:0] list_weight [LIST_DEPTH];
  int unsigned         list_held  = 0;
  int unsigned         list_qidx  = 0;
  logic [63:0]         list_total = '0;
  logic [PCT_BITS-1:0] list_pct   = PCT_RESET;

  res_t        pending_quantiles [$];
  int unsigned sender_idle_pct = 14;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned words_inserted  = 0;
  int unsigned words_cleared   = 0;
  int unsigned words_dropped   = 0;
  int unsigned peak_held       = 0;
  int unsigned cfg_writes      = 0;

  weighted_running_quantile uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic res_t predict_quantile(req_t w);
    logic signed [VALUE_BITS-1:0] v;
    logic [63:0] goal;
    logic [63:0] cum;
    int unsigned pos;
    int unsigned i;
    bit          found;
    res_t        r;
    v = w.sample_value;
    r.insert_dropped = 1'b0;
    if (w.opcode == OP_CLEAR) begin
      list_held  = 0;
      list_total = '0;
      list_qidx  = 0;
    end else if (list_held >= LIST_DEPTH) begin
      r.insert_dropped = 1'b1;
    end else begin
      // new pair goes ahead of the first entry that is not less than it
      pos = 0;
      while (pos < list_held && list_value[pos] < v) pos++;
      for (i = list_held; i > pos; i--) begin
        list_value[i]  = list_value[i-1];
        list_weight[i] = list_weight[i-1];
      end
      list_value[pos]  = v;
      list_weight[pos] = w.sample_weight;
      list_held++;
      list_total += 64'(w.sample_weight);
      // smallest index with 10000 * cum >= pct * total, else the last one
      goal  = 64'(list_pct) * list_total;
      cum   = '0;
      found = 1'b0;
      list_qidx = 0;
      for (i = 0; i < list_held && !found; i++) begin
        cum += 64'(list_weight[i]);
        list_qidx = i;
        found = (cum * 64'(FULL_SCALE) >= goal);
      end
    end
    r.quantile_value = (list_held != 0) ? list_value[list_qidx] : '0;
    r.entry_count    = COUNT_BITS'(list_held);
    return r;
  endfunction

  // one command word; returns in the step of the edge that took it
  task automatic issue_word(logic op, logic [VALUE_BITS-1:0] value,
                            logic [WEIGHT_BITS-1:0] weight);
    req_t w;
    res_t r;
    w.opcode        = op;
    w.sample_value  = value;
    w.sample_weight = weight;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    r = predict_quantile(w);
    pending_quantiles.push_back(r);
    if (op == OP_CLEAR) words_cleared++;
    else if (r.insert_dropped) words_dropped++;
    else words_inserted++;
    if (list_held > peak_held) peak_held = list_held;
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    while (pending_quantiles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_percentile(logic [PCT_BITS-1:0] pct);
    wait_for_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pct;
    @(posedge clk_i);
    list_pct = pct;
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic test_directed_edges();
    issue_word(OP_CLEAR, 32'h7fff_ffff, 16'hffff);  // clear on an empty list
    issue_word(OP_INSERT, 32'h7fff_ffff, 16'h0000); // zero total weight
    issue_word(OP_INSERT, 32'h8000_0000, 16'h0000);
    issue_word(OP_INSERT, 32'h0000_0000, 16'hffff);
    issue_word(OP_INSERT, 32'h0000_0000, 16'h0001); // equal value lands ahead
    issue_word(OP_INSERT, 32'hffff_ffff, 16'h0064);
    issue_word(OP_INSERT, 32'h0000_0001, 16'hffff);
    issue_word(OP_CLEAR, 32'h0000_0000, 16'h0000);
    issue_word(OP_INSERT, 32'h8000_0000, 16'hffff);
  endtask

  task automatic test_percentile_extremes();
    logic [PCT_BITS-1:0] settings [4] = '{14'd10000, 14'd0, PCT_MAX, 14'd1};
    foreach (settings[k]) begin
      set_percentile(settings[k]);
      issue_word(OP_CLEAR, $urandom, WEIGHT_BITS'($urandom));
      issue_word(OP_INSERT, -32'sd5, 16'd3);
      issue_word(OP_INSERT, 32'sd7, 16'd0);  // trailing zero weight
      issue_word(OP_INSERT, 32'sd2, 16'd5);
    end
  endtask

  task automatic test_full_list();
    int n;
    // ascending values at percentile zero keep each insert short
    set_percentile('0);
    issue_word(OP_CLEAR, 32'h0, 16'h0);
    for (n = 0; n < LIST_DEPTH - 1; n++) issue_word(OP_INSERT, n * 4096 - 500000, '1);
    // last place filled from the bottom with the scan saturating at the top
    set_percentile(PCT_MAX);
    issue_word(OP_INSERT, 32'h8000_0000, '1);
    issue_word(OP_INSERT, 32'h7fff_ffff, 16'h0000);
    set_percentile(14'd10000);
    issue_word(OP_INSERT, 32'h0000_0000, 16'hffff);
    issue_word(OP_CLEAR, 32'hffff_ffff, 16'hffff);
    issue_word(OP_INSERT, 32'h0000_007b, 16'h0001);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_plan [3] = '{14, 83, 0};
    int unsigned n;
    int unsigned sel;
    int unsigned clear_pct;
    logic [PCT_BITS-1:0]    pct;
    logic [VALUE_BITS-1:0]  value;
    logic [WEIGHT_BITS-1:0] weight;
    clear_pct = 8;
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      wait_for_quiet();
      for (n = 0; n < RANDOM_WORDS / 3; n++) begin
        if (n % 110 == 0) begin
          case ($urandom_range(0, 5))
            0:       pct = '0;
            1:       pct = FULL_SCALE;
            2:       pct = PCT_MAX;
            3:       pct = PCT_RESET;
            4:       pct = PCT_BITS'($urandom_range(0, 10000));
            default: pct = PCT_BITS'($urandom_range(0, 16383));
          endcase
          set_percentile(pct);
          clear_pct = $urandom_range(2, 15);
        end
        if ($urandom_range(0, 99) < clear_pct) begin
          issue_word(OP_CLEAR, $urandom, WEIGHT_BITS'($urandom));
        end else begin
          sel = $urandom_range(0, 9);
          // narrow pool gives plenty of repeated values
          if (sel < 4) value = $urandom_range(0, 15) - 8;
          else if (sel == 4) value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
          else value = $urandom;
          sel = $urandom_range(0, 9);
          if (sel < 2) weight = '0;
          else if (sel == 2) weight = '1;
          else if (sel < 6) weight = WEIGHT_BITS'($urandom_range(1, 9));
          else weight = WEIGHT_BITS'($urandom_range(0, 65535));
          issue_word(OP_INSERT, value, weight);
        end
      end
    end
  endtask

  // result checking and stall watchdog
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (res_valid_o) begin
        if (pending_quantiles.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word: value %0d count %0d dropped %0b",
                     res_o.quantile_value, res_o.entry_count, res_o.insert_dropped);
        end else begin
          want = pending_quantiles.pop_front();
          if (want.quantile_value !== res_o.quantile_value ||
              want.entry_count !== res_o.entry_count ||
              want.insert_dropped !== res_o.insert_dropped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch at %0t: value exp %0d got %0d, count exp %0d got %0d, %s",
                       $realtime, want.quantile_value, res_o.quantile_value,
                       want.entry_count, res_o.entry_count,
                       $sformatf("dropped exp %0b got %0b",
                                 want.insert_dropped, res_o.insert_dropped));
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("weighted_running_quantile_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_percentile_extremes();
    test_full_list();
    test_random_traffic();
    wait_for_quiet();
    repeat (40) @(posedge clk_i);
    $display("covered %0d inserts, %0d clears, %0d refused inserts, peak list %0d",
             words_inserted, words_cleared, words_dropped, peak_held);
    $display("over %0d percentile settings, %0d result mismatches", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("weighted_running_quantile_test OK");
    end else begin
      $display("weighted_running_quantile_test NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/wrq_pkg.sv
src/wrq_mul_cmp.sv
src/weighted_running_quantile.sv
tb/sv/weighted_running_quantile_test.sv
